[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers included by the checker file rhm_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, with the reset held as part of the property
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rhm_pkg.sv]
// ----------------------------------------------------------------------------
// rhm_pkg
// shared widths, reset value and cell control type of the rpm median filter
// ----------------------------------------------------------------------------
package rhm_pkg;

    localparam int RPM_W = 20;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd5;

    typedef struct packed {
        logic             del_en;
        logic             ins_en;
        logic [RPM_W-1:0] new_val;
    } t_cell_ctl;

endpackage

[rtl/rhm_cell.sv]
// ----------------------------------------------------------------------------
// rhm_cell
// one slot of the sorted history chain: value, age and valid flag, with
// delete by age (pull from right) and sorted insert (push to right)
// ----------------------------------------------------------------------------
module rhm_cell #(
    parameter int AW = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rhm_pkg::t_cell_ctl        i_ctl,
    input  logic [AW-1:0]             i_drop_age,
    input  logic [rhm_pkg::RPM_W-1:0] i_prev_val,
    input  logic                      i_prev_vld,
    input  logic [AW-1:0]             i_prev_age,
    input  logic                      i_prev_ge,
    input  logic [rhm_pkg::RPM_W-1:0] i_next_val,
    input  logic                      i_next_vld,
    input  logic [AW-1:0]             i_next_age,
    input  logic                      i_del_seen,
    output logic [rhm_pkg::RPM_W-1:0] o_val,
    output logic                      o_vld,
    output logic [AW-1:0]             o_age,
    output logic                      o_ge,
    output logic                      o_del_seen
);

    logic [rhm_pkg::RPM_W-1:0] r_val, n_val;
    logic [AW-1:0]             r_age, n_age;
    logic                      r_vld, n_vld;
    logic                      w_ge;
    logic                      w_del;

    assign w_del = i_del_seen | (r_vld && (r_age == i_drop_age));
    assign w_ge  = !r_vld || (r_val > i_ctl.new_val);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        n_age = r_age;
        if (i_ctl.del_en) begin
            if (w_del) begin
                n_val = i_next_val;
                n_vld = i_next_vld;
                n_age = i_next_age;
            end
        end else if (i_ctl.ins_en) begin
            if (w_ge && !i_prev_ge) begin
                n_val = i_ctl.new_val;
                n_vld = 1'b1;
                n_age = '0;
            end else if (w_ge) begin
                n_val = i_prev_val;
                n_vld = i_prev_vld;
                n_age = AW'(i_prev_age + 1'b1);
            end else begin
                n_age = AW'(r_age + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

    assign o_val      = r_val;
    assign o_vld      = r_vld;
    assign o_age      = r_age;
    assign o_ge       = w_ge;
    assign o_del_seen = w_del;

endmodule

[rtl/rpm_history_median_filter_top.sv]
// ----------------------------------------------------------------------------
// rpm_history_median_filter_top
// median of the recent frame rpm estimates, kept in a sorted chain of cells
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry i_frame_rpm (unsigned q16.4);
// a zero estimate leaves the history alone and returns zero, from_history 0
// output channel: o_out_valid / i_out_stall carry o_smoothed_rpm and
// o_from_history, one result per input transaction, in order
// config: i_cfg_wr_en writes i_cfg_wr_data into the history limit; the user
// must write it only while idle, the block itself does not enforce this
// one item at a time: a nonzero estimate steps through delete oldest, sorted
// insert, read lower middle and read upper middle to the output register; a
// zero estimate goes straight from idle to the last step
// o_in_stall is high while an item is in the chain; the next transaction is
// taken once the chain is back to idle, even if a result still waits
// a stalled result holds in the output register; the chain waits in its last
// step until the output register is free
// reset (synchronous, active low) empties the history, sets the limit to 5
// and clears the output valid
// ----------------------------------------------------------------------------
module rpm_history_median_filter_top #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [rhm_pkg::RPM_W-1:0] i_frame_rpm,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [rhm_pkg::RPM_W-1:0] o_smoothed_rpm,
    output logic                      o_from_history,
    input  logic                      i_cfg_wr_en,
    input  logic [rhm_pkg::CFG_W-1:0] i_cfg_wr_data
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int RW = rhm_pkg::RPM_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEL  = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_MLO  = 3'd3;
    localparam logic [2:0] S_MHI  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [rhm_pkg::CFG_W-1:0] r_limit;
    logic [CW-1:0]             r_count;
    logic                      r_drop;
    logic                      r_zero;
    logic [RW-1:0]             r_new;
    logic [RW-1:0]             r_lo;
    logic                      r_out_valid;
    logic [RW-1:0]             r_out_rpm;
    logic                      r_out_hist;

    logic [7:0]                w_lim;
    logic                      w_accept;
    logic                      w_out_free;
    logic [CW-1:0]             w_cnt_m1;
    logic [AW-1:0]             w_lo_idx;
    logic [AW-1:0]             w_hi_idx;
    logic [RW:0]               w_sum;
    rhm_pkg::t_cell_ctl        w_ctl;

    logic [RW-1:0]        w_val [HISTORY_DEPTH];
    logic                 w_vld [HISTORY_DEPTH];
    logic [AW-1:0]        w_age [HISTORY_DEPTH];
    logic                 w_ge  [HISTORY_DEPTH];
    logic                 w_dsn [HISTORY_DEPTH];

    // effective limit: zero counts as one, capped at the depth
    always_comb begin
        w_lim = {3'b000, r_limit};
        if (r_limit == '0) begin
            w_lim = 8'd1;
        end else if (w_lim > 8'(HISTORY_DEPTH)) begin
            w_lim = 8'(HISTORY_DEPTH);
        end
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cnt_m1   = CW'(r_count - 1'b1);
    assign w_lo_idx   = AW'(w_cnt_m1 >> 1);
    assign w_hi_idx   = AW'(r_count >> 1);
    assign w_sum      = {1'b0, r_lo} + {1'b0, w_val[w_hi_idx]};

    assign w_ctl.del_en  = (r_state == S_DEL) && r_drop;
    assign w_ctl.ins_en  = (r_state == S_INS);
    assign w_ctl.new_val = r_new;

    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
            logic [RW-1:0] w_pv;
            logic          w_pvd;
            logic [AW-1:0] w_pa;
            logic          w_pg;
            logic          w_pd;
            logic [RW-1:0] w_nv;
            logic          w_nvd;
            logic [AW-1:0] w_na;

            if (gi == 0) begin : g_head
                assign w_pv  = '0;
                assign w_pvd = 1'b0;
                assign w_pa  = '0;
                assign w_pg  = 1'b0;
                assign w_pd  = 1'b0;
            end else begin : g_body
                assign w_pv  = w_val[gi-1];
                assign w_pvd = w_vld[gi-1];
                assign w_pa  = w_age[gi-1];
                assign w_pg  = w_ge[gi-1];
                assign w_pd  = w_dsn[gi-1];
            end

            if (gi == HISTORY_DEPTH - 1) begin : g_tail
                assign w_nv  = '0;
                assign w_nvd = 1'b0;
                assign w_na  = '0;
            end else begin : g_link
                assign w_nv  = w_val[gi+1];
                assign w_nvd = w_vld[gi+1];
                assign w_na  = w_age[gi+1];
            end

            rhm_cell #(
                .AW(AW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_drop_age (w_cnt_m1[AW-1:0]),
                .i_prev_val (w_pv),
                .i_prev_vld (w_pvd),
                .i_prev_age (w_pa),
                .i_prev_ge  (w_pg),
                .i_next_val (w_nv),
                .i_next_vld (w_nvd),
                .i_next_age (w_na),
                .i_del_seen (w_pd),
                .o_val      (w_val[gi]),
                .o_vld      (w_vld[gi]),
                .o_age      (w_age[gi]),
                .o_ge       (w_ge[gi]),
                .o_del_seen (w_dsn[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_frame_rpm == '0) ? S_MHI : S_DEL;
                end
            end
            S_DEL:  n_state = S_INS;
            S_INS:  n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= rhm_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if ((r_state == S_INS) && !r_drop) begin
                r_count <= CW'(r_count + 1'b1);
            end
            if ((r_state == S_MHI) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new  <= i_frame_rpm;
            r_zero <= (i_frame_rpm == '0);
            r_drop <= ({{(8-CW){1'b0}}, r_count} >= w_lim);
        end
        if (r_state == S_MLO) begin
            r_lo <= w_val[w_lo_idx];
        end
        if ((r_state == S_MHI) && w_out_free) begin
            r_out_rpm  <= r_zero ? '0 : w_sum[RW:1];
            r_out_hist <= !r_zero;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_smoothed_rpm = r_out_rpm;
    assign o_from_history = r_out_hist;

endmodule

[rtl/rhm_checker.sv]
// ----------------------------------------------------------------------------
// rhm_checker
// port-level checks of the rpm median filter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [rhm_pkg::RPM_W-1:0] o_smoothed_rpm,
    input logic                      o_from_history
);

    // stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_smoothed_rpm) && $stable(o_from_history)),
        "stalled result changed")

    // one item in flight: input stalls right after a transaction
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) |=> o_in_stall,
        "input not stalled after transaction")

    // passed-through results are always zero
    `ASSERT_CLK(a_pass_zero, i_clk, i_rst_n,
        (o_out_valid && !o_from_history) |-> (o_smoothed_rpm == '0),
        "pass-through result not zero")

    // a median of nonzero estimates is never zero
    `ASSERT_CLK(a_hist_nonzero, i_clk, i_rst_n,
        (o_out_valid && o_from_history) |-> (o_smoothed_rpm != '0),
        "history median is zero")

endmodule

bind rpm_history_median_filter_top rhm_checker u_rhm_checker (.*);
